// ===== src/btff_pkg.sv =====
// Shared types, constants and tag helpers for the boundary-tag first-fit allocator.
// Used by btff_ctrl and boundary_tag_first_fit_allocator; depends on nothing.
`default_nettype none
package btff_pkg;

	// internal byte-offset arithmetic width (heap never exceeds 64 KiB)
	localparam int OFF_W = 20;
	// one boundary tag: size in [17:3], allocated flag in [0]
	localparam int TAG_W = 18;
	localparam int LIMIT_W = 17;

	localparam logic [OFF_W-1:0] OVERHEAD = OFF_W'(16);
	localparam logic [OFF_W-1:0] TAG_BYTES = OFF_W'(8);
	localparam logic [OFF_W-1:0] MIN_SPLIT = OFF_W'(24);

	// operation codes
	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FREE = 2'd1;
	localparam logic [1:0] FUNC_REALLOC = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [15:0] addr;
		logic [15:0] size;
	} btff_in_t;

	typedef struct packed {
		logic [15:0] result_addr;
		logic status;
		logic moved;
		logic [15:0] copy_bytes;
	} btff_out_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_VW_RD,
		S_VW_CHK,
		S_RA_RDN,
		S_RA_CHKN,
		S_AW_RD,
		S_AW_CHK,
		S_GROW,
		S_GCHK,
		S_GW_EH,
		S_GW_EF,
		S_PL_W0,
		S_PL_W1,
		S_PL_W2,
		S_PL_W3,
		S_FR_RDN,
		S_FR_RDP,
		S_FR_CHKP,
		S_FR_WH,
		S_FR_WF,
		S_DONE
	} btff_state_t;

	// build a tag from an allocated flag and a byte size
	function automatic logic [TAG_W-1:0] mk_tag(input logic alloc, input logic [OFF_W-1:0] sz);
		mk_tag = {sz[TAG_W-1:3], 2'b00, alloc};
	endfunction

	// byte size held in a tag
	function automatic logic [OFF_W-1:0] tag_size(input logic [TAG_W-1:0] t);
		tag_size = OFF_W'({t[TAG_W-1:3], 3'b000});
	endfunction

endpackage
`default_nettype wire

// ===== src/btff_ram.sv =====
// Generic single-port RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module btff_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 8192
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one word per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// ===== src/btff_ctrl.sv =====
// Sequencer and shared address/size datapath of the allocator: walks, grows,
// places, splits and coalesces blocks through one tag RAM port. Uses btff_pkg.
`default_nettype none
module btff_ctrl #(
	parameter int MAX_HEAP_BYTES = 65536,
	parameter int CHUNK_BYTES = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [btff_pkg::OFF_W-1:0] lim,
	input wire logic in_valid,
	output logic in_stall,
	input wire btff_pkg::btff_in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output btff_pkg::btff_out_t out_data,
	output logic mem_we,
	output logic [$clog2(MAX_HEAP_BYTES/8)-1:0] mem_idx,
	output logic [btff_pkg::TAG_W-1:0] mem_wdata,
	input wire logic [btff_pkg::TAG_W-1:0] mem_rdata
);

	localparam int OW = btff_pkg::OFF_W;
	localparam int IW = $clog2(MAX_HEAP_BYTES/8);
	localparam logic [OW-1:0] CHUNK = OW'(CHUNK_BYTES);
	localparam logic [OW-1:0] OVH = btff_pkg::OVERHEAD;
	localparam logic [OW-1:0] TB = btff_pkg::TAG_BYTES;

	btff_pkg::btff_state_t state_q, state_d;
	logic [2:0] init_q;
	logic [1:0] func_q;
	logic [15:0] addr_q;
	logic [OW-1:0] s_q, hv_q, hw_q, p_q, b_q, sz_q, ext_q, heap_end_q;
	logic [btff_pkg::TAG_W-1:0] ntag_q;
	logic pend_q;
	logic [15:0] res_q, copy_q;
	logic status_q, moved_q;
	logic out_valid_q;
	btff_pkg::btff_out_t out_q;

	logic accept;
	logic [OW-1:0] s_in, rd_size, ep, sum_end, plsz, fsz, mem_off;
	logic [OW-1:0] fr_start, fr_tot, nsz;
	logic rd_free, split, is_al, out_go, fits_here, fits_next;

	// shared decode of the current tag and working values
	always_comb begin
		accept = in_valid && (state_q == btff_pkg::S_IDLE);
		s_in = ((OW'(in_data.size)) + OW'(7)) & ~OW'(7);
		is_al = (in_data.func == btff_pkg::FUNC_ALLOC) ||
			((in_data.func == btff_pkg::FUNC_REALLOC) && (in_data.addr == 16'd0));
		rd_size = btff_pkg::tag_size(mem_rdata);
		rd_free = !mem_rdata[0];
		ep = heap_end_q - OVH;
		sum_end = heap_end_q + ext_q;
		split = sz_q >= (s_q + btff_pkg::MIN_SPLIT);
		plsz = split ? s_q : sz_q;
		fits_here = rd_free && (rd_size >= s_q);
		fits_next = rd_free && (s_q <= (b_q + rd_size + OVH));
		nsz = btff_pkg::tag_size(ntag_q);
		fsz = ntag_q[0] ? b_q : (b_q + nsz + OVH);
		if (rd_free) begin
			fr_start = hv_q - OVH - rd_size;
			fr_tot = rd_size + fsz + OVH;
		end else begin
			fr_start = hv_q;
			fr_tot = fsz;
		end
		out_go = !out_valid_q || !out_stall;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			btff_pkg::S_INIT: begin
				if (init_q == 3'd5) state_d = btff_pkg::S_IDLE;
			end
			btff_pkg::S_IDLE: begin
				if (accept) begin
					if (is_al) begin
						state_d = (s_in == '0) ? btff_pkg::S_DONE : btff_pkg::S_AW_RD;
					end else if ((in_data.func == btff_pkg::FUNC_FREE) ||
						(in_data.func == btff_pkg::FUNC_REALLOC)) begin
						state_d = (in_data.addr < 16'd8) ? btff_pkg::S_DONE : btff_pkg::S_VW_RD;
					end else begin
						state_d = btff_pkg::S_DONE;
					end
				end
			end
			btff_pkg::S_VW_RD: begin
				state_d = ((p_q < ep) && (p_q <= hv_q)) ? btff_pkg::S_VW_CHK : btff_pkg::S_DONE;
			end
			btff_pkg::S_VW_CHK: begin
				if (p_q == hv_q) begin
					if (rd_free) state_d = btff_pkg::S_DONE;
					else if ((func_q == btff_pkg::FUNC_FREE) || (s_q == '0))
						state_d = btff_pkg::S_FR_RDN;
					else if (s_q <= rd_size) state_d = btff_pkg::S_PL_W0;
					else state_d = btff_pkg::S_RA_RDN;
				end else begin
					state_d = btff_pkg::S_VW_RD;
				end
			end
			btff_pkg::S_RA_RDN: state_d = btff_pkg::S_RA_CHKN;
			btff_pkg::S_RA_CHKN: state_d = fits_next ? btff_pkg::S_PL_W0 : btff_pkg::S_AW_RD;
			btff_pkg::S_AW_RD: state_d = (p_q < ep) ? btff_pkg::S_AW_CHK : btff_pkg::S_GROW;
			btff_pkg::S_AW_CHK: state_d = fits_here ? btff_pkg::S_PL_W0 : btff_pkg::S_AW_RD;
			btff_pkg::S_GROW: begin
				if (ext_q >= (s_q + OVH)) state_d = btff_pkg::S_GCHK;
			end
			btff_pkg::S_GCHK: state_d = (sum_end > lim) ? btff_pkg::S_DONE : btff_pkg::S_GW_EH;
			btff_pkg::S_GW_EH: state_d = btff_pkg::S_GW_EF;
			btff_pkg::S_GW_EF: state_d = btff_pkg::S_PL_W0;
			btff_pkg::S_PL_W0: state_d = btff_pkg::S_PL_W1;
			btff_pkg::S_PL_W1: begin
				if (split) state_d = btff_pkg::S_PL_W2;
				else state_d = pend_q ? btff_pkg::S_FR_RDN : btff_pkg::S_DONE;
			end
			btff_pkg::S_PL_W2: state_d = btff_pkg::S_PL_W3;
			btff_pkg::S_PL_W3: state_d = pend_q ? btff_pkg::S_FR_RDN : btff_pkg::S_DONE;
			btff_pkg::S_FR_RDN: state_d = btff_pkg::S_FR_RDP;
			btff_pkg::S_FR_RDP: state_d = btff_pkg::S_FR_CHKP;
			btff_pkg::S_FR_CHKP: state_d = btff_pkg::S_FR_WH;
			btff_pkg::S_FR_WH: state_d = btff_pkg::S_FR_WF;
			btff_pkg::S_FR_WF: state_d = btff_pkg::S_DONE;
			btff_pkg::S_DONE: begin
				if (out_go) state_d = btff_pkg::S_IDLE;
			end
			default: state_d = btff_pkg::S_INIT;
		endcase
	end

	// tag RAM port: one read or write per cycle
	always_comb begin
		mem_we = 1'b0;
		mem_off = p_q;
		mem_wdata = btff_pkg::mk_tag(1'b1, '0);
		case (state_q)
			btff_pkg::S_INIT: begin
				mem_we = 1'b1;
				case (init_q)
					3'd0: mem_off = '0;
					3'd1: mem_off = TB;
					3'd2: begin
						mem_off = OVH;
						mem_wdata = btff_pkg::mk_tag(1'b0, CHUNK - OW'(48));
					end
					3'd3: begin
						mem_off = CHUNK - OW'(24);
						mem_wdata = btff_pkg::mk_tag(1'b0, CHUNK - OW'(48));
					end
					3'd4: mem_off = CHUNK - OVH;
					default: mem_off = CHUNK - TB;
				endcase
			end
			btff_pkg::S_RA_RDN, btff_pkg::S_FR_RDN: mem_off = hv_q + b_q + OVH;
			btff_pkg::S_FR_RDP: mem_off = hv_q - TB;
			btff_pkg::S_GW_EH: begin
				mem_we = 1'b1;
				mem_off = heap_end_q - OVH;
			end
			btff_pkg::S_GW_EF: begin
				mem_we = 1'b1;
				mem_off = heap_end_q - TB;
			end
			btff_pkg::S_PL_W0: begin
				mem_we = 1'b1;
				mem_off = hw_q;
				mem_wdata = btff_pkg::mk_tag(1'b1, plsz);
			end
			btff_pkg::S_PL_W1: begin
				mem_we = 1'b1;
				mem_off = hw_q + TB + plsz;
				mem_wdata = btff_pkg::mk_tag(1'b1, plsz);
			end
			btff_pkg::S_PL_W2: begin
				mem_we = 1'b1;
				mem_off = hw_q + s_q + OVH;
				mem_wdata = btff_pkg::mk_tag(1'b0, sz_q - s_q - OVH);
			end
			btff_pkg::S_PL_W3: begin
				mem_we = 1'b1;
				mem_off = hw_q + sz_q + TB;
				mem_wdata = btff_pkg::mk_tag(1'b0, sz_q - s_q - OVH);
			end
			btff_pkg::S_FR_WH: begin
				mem_we = 1'b1;
				mem_off = hw_q;
				mem_wdata = btff_pkg::mk_tag(1'b0, sz_q);
			end
			btff_pkg::S_FR_WF: begin
				mem_we = 1'b1;
				mem_off = hw_q + TB + sz_q;
				mem_wdata = btff_pkg::mk_tag(1'b0, sz_q);
			end
			default: mem_off = p_q;
		endcase
		mem_idx = mem_off[IW+2:3];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btff_pkg::S_INIT;
			init_q <= 3'd0;
			heap_end_q <= CHUNK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == btff_pkg::S_INIT) init_q <= init_q + 3'd1;
			if ((state_q == btff_pkg::S_GCHK) && !(sum_end > lim)) heap_end_q <= sum_end;
			if ((state_q == btff_pkg::S_DONE) && out_go) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			btff_pkg::S_IDLE: begin
				if (accept) begin
					func_q <= in_data.func;
					addr_q <= in_data.addr;
					s_q <= s_in;
					hv_q <= OW'(in_data.addr) - TB;
					p_q <= OVH;
					pend_q <= 1'b0;
					res_q <= '0;
					status_q <= 1'b0;
					moved_q <= 1'b0;
					copy_q <= '0;
				end
			end
			btff_pkg::S_VW_CHK: begin
				if (p_q == hv_q) begin
					b_q <= rd_size;
					hw_q <= hv_q;
					sz_q <= rd_size;
					// grant in place here for a realloc of a live block that does not grow
					if ((func_q == btff_pkg::FUNC_REALLOC) && !rd_free &&
						(s_q != '0) && (s_q <= rd_size)) res_q <= addr_q;
				end else begin
					p_q <= p_q + rd_size + OVH;
				end
			end
			btff_pkg::S_RA_CHKN: begin
				if (fits_next) begin
					sz_q <= b_q + rd_size + OVH;
					res_q <= addr_q;
				end else begin
					pend_q <= 1'b1;
					p_q <= OVH;
				end
			end
			btff_pkg::S_AW_RD: begin
				if (!(p_q < ep)) ext_q <= CHUNK;
			end
			btff_pkg::S_AW_CHK: begin
				if (fits_here) begin
					hw_q <= p_q;
					sz_q <= rd_size;
					res_q <= p_q[15:0] + 16'd8;
				end else begin
					p_q <= p_q + rd_size + OVH;
				end
			end
			btff_pkg::S_GROW: begin
				if (ext_q < (s_q + OVH)) ext_q <= ext_q + CHUNK;
			end
			btff_pkg::S_GCHK: begin
				if (sum_end > lim) begin
					status_q <= 1'b1;
					res_q <= '0;
				end else begin
					hw_q <= heap_end_q - OVH;
					sz_q <= ext_q - OVH;
					res_q <= heap_end_q[15:0] - 16'd8;
				end
			end
			btff_pkg::S_FR_RDN: begin
				if (pend_q) begin
					moved_q <= 1'b1;
					copy_q <= b_q[15:0];
				end
			end
			btff_pkg::S_FR_RDP: ntag_q <= mem_rdata;
			btff_pkg::S_FR_CHKP: begin
				hw_q <= fr_start;
				sz_q <= fr_tot;
			end
			btff_pkg::S_DONE: begin
				if (out_go) begin
					out_q.result_addr <= res_q;
					out_q.status <= status_q;
					out_q.moved <= moved_q;
					out_q.copy_bytes <= copy_q;
				end
			end
			default: begin
				ntag_q <= ntag_q;
			end
		endcase
	end

	assign in_stall = (state_q != btff_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== src/boundary_tag_first_fit_allocator.sv =====
// Top level of the boundary-tag first-fit heap allocator: limit register,
// tag RAM and sequencer. Uses btff_pkg, btff_ram and btff_ctrl.
//
// Each transaction is handled alone by a sequencer sharing one tag RAM port,
// one tag read or write per cycle. After reset the sequencer writes the
// initial heap tags before the first transaction is taken. An allocate walks
// the blocks from the start of the heap, grows the heap by whole chunks when
// no block fits, then writes the tags of the placed block and any split
// remainder; free or realloc first walks the block chain up to the given
// address to validate it, and a free then reads both neighbours' tags and
// writes the coalesced block's header and footer.
`default_nettype none
module boundary_tag_first_fit_allocator #(
	parameter int MAX_HEAP_BYTES = 65536,
	parameter int CHUNK_BYTES = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [btff_pkg::LIMIT_W-1:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire btff_pkg::btff_in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output btff_pkg::btff_out_t out_data
);

	localparam int DEPTH = MAX_HEAP_BYTES / 8;
	localparam int IW = $clog2(DEPTH);
	localparam int CAP = (MAX_HEAP_BYTES < 65536) ? MAX_HEAP_BYTES : 65536;
	localparam logic [btff_pkg::OFF_W-1:0] CAP_OFF = btff_pkg::OFF_W'(CAP);

	logic [btff_pkg::LIMIT_W-1:0] heap_limit_q;
	logic [btff_pkg::OFF_W-1:0] lim;
	logic mem_we;
	logic [IW-1:0] mem_idx;
	logic [btff_pkg::TAG_W-1:0] mem_wdata, mem_rdata;

	// hold the heap size limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= btff_pkg::LIMIT_W'(65536);
		end else if (cfg_we) begin
			heap_limit_q <= cfg_wdata;
		end
	end

	// clamp the limit to the heap capacity
	always_comb begin
		if (btff_pkg::OFF_W'(heap_limit_q) > CAP_OFF) lim = CAP_OFF;
		else lim = btff_pkg::OFF_W'(heap_limit_q);
	end

	btff_ram #(
		.WIDTH(btff_pkg::TAG_W),
		.DEPTH(DEPTH)
	) u_tags (
		.clk(clk),
		.we(mem_we),
		.addr(mem_idx),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	btff_ctrl #(
		.MAX_HEAP_BYTES(MAX_HEAP_BYTES),
		.CHUNK_BYTES(CHUNK_BYTES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.lim(lim),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.mem_we(mem_we),
		.mem_idx(mem_idx),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

endmodule
`default_nettype wire
